// ----- rtl/core/matrix_chain_order_cost_assert.svh -----
// ----------------------------------------------------------------------------
// matrix chain order cost assertion macros
// concurrent check macros used by matrix_chain_order_cost.sv
// ----------------------------------------------------------------------------
`ifndef MATRIX_CHAIN_ORDER_COST_ASSERT_SVH
`define MATRIX_CHAIN_ORDER_COST_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MCOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcoc assertion failed");

// next-cycle implication
`define MCOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcoc assertion failed");

`else

`define MCOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define MCOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/mcoc_pkg.sv -----
// ----------------------------------------------------------------------------
// mcoc_pkg
// types, codes and helpers shared by the matrix chain order cost block
// ----------------------------------------------------------------------------
package mcoc_pkg;

    localparam int DIM_PORT_W = 16;
    localparam int COST_W     = 64;
    localparam int STATUS_W   = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_DIAG,
        S_IV0,
        S_IV1,
        S_IV2,
        S_K0,
        S_K1,
        S_K2,
        S_K3,
        S_WR,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        C_NOP,
        C_LOAD,
        C_CHECK,
        C_DIAG,
        C_RD_DI,
        C_RD_DJ,
        C_MUL_DIJ,
        C_K_RD0,
        C_K_RD1,
        C_K_SUM,
        C_K_ACC,
        C_WRITE,
        C_EMIT
    } t_cmd;

    typedef struct packed {
        logic overflow;
        logic short_chain;
        logic single;
        logic last_diag;
        logic last_k;
        logic last_iv;
        logic last_len;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

endpackage

// ----- rtl/core/matrix_chain_order_cost.sv -----
// ----------------------------------------------------------------------------
// matrix_chain_order_cost
// Takes a chain of matrix dimensions, one item per cycle, the final one
// flagged by i_last, and returns the least scalar-multiplication count for
// the whole chain with a status (0 ok, 1 fewer than two dimensions, 2 more
// than MAX_MATRICES+1 dimensions, extra ones dropped). Loading runs at one
// item per cycle. After the flagged item the input stalls while the interval
// dynamic program runs on one shared multiply-add-min unit, with one read
// port on the dimension store and one on the cost table. For n matrices it
// runs a check step, clears the n diagonal entries, and for each interval
// reads and multiplies its outer dimensions, tries every split (read, read,
// sum, min) and writes the best cost; an emit step fills the output register.
// Error and single-matrix chains go from the check step straight to emit.
// The emit cycle, and with it the input, waits while an earlier result is
// still held in the output register. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "matrix_chain_order_cost_assert.svh"

module matrix_chain_order_cost
    import mcoc_pkg::*;
#(
    parameter int MAX_MATRICES = 32,
    parameter int DIM_BITS     = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [DIM_PORT_W-1:0] i_dim,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COST_W-1:0]     o_min_cost,
    output logic [STATUS_W-1:0]   o_status
);

    t_cmd     w_cmd;
    t_dp_stat w_stat;

    mcoc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_last),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    mcoc_dp #(
        .MAX_MATRICES (MAX_MATRICES),
        .DIM_BITS     (DIM_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_dim       (i_dim),
        .i_out_ready (i_out_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_min_cost  (o_min_cost),
        .o_status    (o_status)
    );

    // a result never overwrites one still waiting
    `MCOC_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, w_cmd == C_EMIT, !(o_out_valid && !i_out_ready))
    // the compute phase stalls input right after the flagged item
    `MCOC_ASSERT_NXT(a_last_stall, i_clk, i_rst_n, i_in_valid && o_in_ready && i_last, !o_in_ready)
    // a new result only appears after an emit command
    `MCOC_ASSERT_IMP(a_out_src, i_clk, i_rst_n, $rose(o_out_valid), $past(w_cmd) == C_EMIT)

endmodule

// ----- rtl/core/mcoc_ram.sv -----
// ----------------------------------------------------------------------------
// mcoc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mcoc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 33
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/mcoc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcoc_ctrl
// sequencer for load, diagonal clear, interval sweep and result hand-off
// ----------------------------------------------------------------------------
module mcoc_ctrl
    import mcoc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_last,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_cmd     o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid && i_in_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.overflow || i_stat.short_chain || i_stat.single) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DIAG;
                end
            end
            S_DIAG: begin
                if (i_stat.last_diag) begin
                    n_state = S_IV0;
                end
            end
            S_IV0: n_state = S_IV1;
            S_IV1: n_state = S_IV2;
            S_IV2: n_state = S_K0;
            S_K0:  n_state = S_K1;
            S_K1:  n_state = S_K2;
            S_K2:  n_state = S_K3;
            S_K3: begin
                n_state = i_stat.last_k ? S_WR : S_K0;
            end
            S_WR: begin
                n_state = (i_stat.last_iv && i_stat.last_len) ? S_EMIT : S_IV0;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = C_NOP;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd      = i_in_valid ? C_LOAD : C_NOP;
            end
            S_CHECK: o_cmd = C_CHECK;
            S_DIAG:  o_cmd = C_DIAG;
            S_IV0:   o_cmd = C_RD_DI;
            S_IV1:   o_cmd = C_RD_DJ;
            S_IV2:   o_cmd = C_MUL_DIJ;
            S_K0:    o_cmd = C_K_RD0;
            S_K1:    o_cmd = C_K_RD1;
            S_K2:    o_cmd = C_K_SUM;
            S_K3:    o_cmd = C_K_ACC;
            S_WR:    o_cmd = C_WRITE;
            S_EMIT:  o_cmd = i_stat.out_busy ? C_NOP : C_EMIT;
            default: o_cmd = C_NOP;
        endcase
    end

endmodule

// ----- rtl/core/mcoc_dp.sv -----
// ----------------------------------------------------------------------------
// mcoc_dp
// dimension store, cost table, loop counters, multiply-add-min unit and
// result register
// ----------------------------------------------------------------------------
module mcoc_dp
    import mcoc_pkg::*;
#(
    parameter int MAX_MATRICES = 32,
    parameter int DIM_BITS     = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [DIM_PORT_W-1:0] i_dim,
    input  logic                  i_out_ready,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    output logic [COST_W-1:0]     o_min_cost,
    output logic [STATUS_W-1:0]   o_status
);

    localparam int DIM_W       = (DIM_BITS < DIM_PORT_W) ? DIM_BITS : DIM_PORT_W;
    localparam int STORE_DEPTH = MAX_MATRICES + 1;
    localparam int IDX_W       = $clog2(MAX_MATRICES + 1);
    localparam int CNT_W       = $clog2(MAX_MATRICES + 2);
    localparam int CI_W        = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
    localparam int COST_DEPTH  = 1 << (2 * CI_W);

    logic [CNT_W-1:0]    r_count;
    logic                r_over;
    logic [IDX_W-1:0]    r_nmat;
    logic [IDX_W-1:0]    r_len;
    logic [IDX_W-1:0]    r_i;
    logic [IDX_W-1:0]    r_j;
    logic [IDX_W-1:0]    r_k;
    logic [DIM_W-1:0]    r_di;
    logic [DIM_W-1:0]    r_dk;
    logic [2*DIM_W-1:0]  r_dij;
    logic [3*DIM_W-1:0]  r_prod;
    logic [COST_W-1:0]   r_cl;
    logic [COST_W-1:0]   r_sum;
    logic [COST_W-1:0]   r_best;
    logic [COST_W-1:0]   r_result;
    t_status             r_status;
    logic                r_out_valid;
    logic [COST_W-1:0]   r_out_cost;
    t_status             r_out_status;

    logic                w_dim_we;
    logic [IDX_W-1:0]    w_dim_raddr;
    logic [DIM_W-1:0]    w_dim_rdata;
    logic                w_cost_we;
    logic [2*CI_W-1:0]   w_cost_waddr;
    logic [COST_W-1:0]   w_cost_wdata;
    logic [2*CI_W-1:0]   w_cost_raddr;
    logic [COST_W-1:0]   w_cost_rdata;
    logic [IDX_W-1:0]    w_nmat_m1;
    logic [IDX_W-1:0]    w_k1;
    logic [IDX_W-1:0]    w_j1;
    logic [COST_W-1:0]   w_cand;

    assign w_nmat_m1 = IDX_W'(r_nmat - IDX_W'(1));
    assign w_k1      = IDX_W'(r_k + IDX_W'(1));
    assign w_j1      = IDX_W'(r_j + IDX_W'(1));
    assign w_cand    = sat_add(r_sum, COST_W'(r_prod));

    assign w_dim_we = (i_cmd == C_LOAD) && (r_count < CNT_W'(STORE_DEPTH));

    mcoc_ram #(
        .WIDTH (DIM_W),
        .DEPTH (STORE_DEPTH)
    ) u_dim_ram (
        .i_clk   (i_clk),
        .i_we    (w_dim_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_dim[DIM_W-1:0]),
        .i_raddr (w_dim_raddr),
        .o_rdata (w_dim_rdata)
    );

    mcoc_ram #(
        .WIDTH (COST_W),
        .DEPTH (COST_DEPTH)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (w_cost_we),
        .i_waddr (w_cost_waddr),
        .i_wdata (w_cost_wdata),
        .i_raddr (w_cost_raddr),
        .o_rdata (w_cost_rdata)
    );

    // read and write address selection
    always_comb begin
        w_dim_raddr  = r_i;
        w_cost_raddr = {r_i[CI_W-1:0], r_k[CI_W-1:0]};
        w_cost_we    = 1'b0;
        w_cost_waddr = {r_i[CI_W-1:0], r_j[CI_W-1:0]};
        w_cost_wdata = r_best;
        unique case (i_cmd)
            C_RD_DI: w_dim_raddr = r_i;
            C_RD_DJ: w_dim_raddr = w_j1;
            C_K_RD0: w_dim_raddr = w_k1;
            C_K_RD1: w_cost_raddr = {w_k1[CI_W-1:0], r_j[CI_W-1:0]};
            C_DIAG: begin
                w_cost_we    = 1'b1;
                w_cost_waddr = {r_i[CI_W-1:0], r_i[CI_W-1:0]};
                w_cost_wdata = '0;
            end
            C_WRITE: w_cost_we = 1'b1;
            default: w_cost_we = 1'b0;
        endcase
    end

    // chain bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_over  <= 1'b0;
        end else if (i_cmd == C_LOAD) begin
            if (r_count < CNT_W'(STORE_DEPTH)) begin
                r_count <= CNT_W'(r_count + CNT_W'(1));
            end else begin
                r_over <= 1'b1;
            end
        end else if (i_cmd == C_CHECK) begin
            r_count <= '0;
            r_over  <= 1'b0;
        end
    end

    // loop counters and arithmetic
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            C_CHECK: begin
                r_nmat   <= IDX_W'(r_count - CNT_W'(1));
                r_result <= '0;
                r_i      <= '0;
                if (r_over) begin
                    r_status <= ST_OVER;
                end else if (r_count < CNT_W'(2)) begin
                    r_status <= ST_SHORT;
                end else begin
                    r_status <= ST_OK;
                end
            end
            C_DIAG: begin
                if (r_i == w_nmat_m1) begin
                    r_len <= IDX_W'(2);
                    r_i   <= '0;
                    r_j   <= IDX_W'(1);
                end else begin
                    r_i <= IDX_W'(r_i + IDX_W'(1));
                end
            end
            C_RD_DJ: r_di <= w_dim_rdata;
            C_MUL_DIJ: begin
                r_dij  <= r_di * w_dim_rdata;
                r_k    <= r_i;
                r_best <= {COST_W{1'b1}};
            end
            C_K_RD1: begin
                r_dk <= w_dim_rdata;
                r_cl <= w_cost_rdata;
            end
            C_K_SUM: begin
                r_prod <= r_dij * r_dk;
                r_sum  <= sat_add(r_cl, w_cost_rdata);
            end
            C_K_ACC: begin
                if (w_cand < r_best) begin
                    r_best <= w_cand;
                end
                if (w_k1 != r_j) begin
                    r_k <= w_k1;
                end
            end
            C_WRITE: begin
                if (r_j == w_nmat_m1) begin
                    if (r_len == r_nmat) begin
                        r_result <= r_best;
                    end else begin
                        r_len <= IDX_W'(r_len + IDX_W'(1));
                        r_i   <= '0;
                        r_j   <= r_len;
                    end
                end else begin
                    r_i <= IDX_W'(r_i + IDX_W'(1));
                    r_j <= w_j1;
                end
            end
            default: begin
                r_i <= r_i;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == C_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_EMIT) begin
            r_out_cost   <= r_result;
            r_out_status <= r_status;
        end
    end

    assign o_stat.overflow    = r_over;
    assign o_stat.short_chain = r_count < CNT_W'(2);
    assign o_stat.single      = r_count == CNT_W'(2);
    assign o_stat.last_diag   = r_i == w_nmat_m1;
    assign o_stat.last_k      = w_k1 == r_j;
    assign o_stat.last_iv     = r_j == w_nmat_m1;
    assign o_stat.last_len    = r_len == r_nmat;
    assign o_stat.out_busy    = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_min_cost  = r_out_cost;
    assign o_status    = r_out_status;

endmodule

// ----- tb/tb_matrix_chain_order_cost.sv -----
// ----------------------------------------------------------------------------
// tb_matrix_chain_order_cost
// Feeds chains of matrix dimensions through the valid/ready input, one
// dimension per item, and checks every returned cost and status against an
// in-bench interval dynamic program. Covers short chains, single matrices,
// full and overflowing stores, extreme dimensions, random idling on both
// sides and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_matrix_chain_order_cost;
    timeunit 1ns;
    timeprecision 1ps;

    import mcoc_pkg::*;

    localparam int MAX_MATRICES = 32;
    localparam int DIM_BITS     = 16;
    localparam int STORE_DEPTH  = MAX_MATRICES + 1;
    localparam int ITEM_TARGET  = 1650;
    localparam int IDLE_LIMIT   = 100000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 64;

    typedef logic [DIM_PORT_W-1:0] t_dim_q [$];

    typedef struct {
        logic [COST_W-1:0] cost;
        t_status           status;
    } t_chain_result;

    class t_chain_cost_board;
        logic [DIM_PORT_W-1:0] dims_held [0:STORE_DEPTH-1];
        int unsigned           dims_count;
        bit                    store_overflow;
        t_chain_result         pending_results [$];
        int unsigned           errors;

        function new();
            dims_count     = 0;
            store_overflow = 1'b0;
            errors         = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic [COST_W-1:0] add_clamped(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
            logic [COST_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s[COST_W]) begin
                return {COST_W{1'b1}};
            end
            return s[COST_W-1:0];
        endfunction

        function logic [COST_W-1:0] least_cost(int nmat);
            logic [COST_W-1:0] tbl [0:MAX_MATRICES-1][0:MAX_MATRICES-1];
            logic [COST_W-1:0] best;
            logic [COST_W-1:0] prod;
            logic [COST_W-1:0] c;
            int                len;
            int                i;
            int                j;
            int                k;
            for (i = 0; i < nmat; i++) begin
                tbl[i][i] = '0;
            end
            for (len = 2; len <= nmat; len++) begin
                for (i = 0; i + len <= nmat; i++) begin
                    j    = i + len - 1;
                    best = {COST_W{1'b1}};
                    for (k = i; k < j; k++) begin
                        prod = COST_W'(dims_held[i]) * COST_W'(dims_held[k+1])
                               * COST_W'(dims_held[j+1]);
                        c = add_clamped(add_clamped(tbl[i][k], tbl[k+1][j]), prod);
                        if (c < best) begin
                            best = c;
                        end
                    end
                    tbl[i][j] = best;
                end
            end
            return tbl[0][nmat-1];
        endfunction

        function void note_dim(logic [DIM_PORT_W-1:0] dim, logic last);
            t_chain_result want;
            if (dims_count < STORE_DEPTH) begin
                dims_held[dims_count] = dim & DIM_PORT_W'((1 << DIM_BITS) - 1);
                dims_count++;
            end else begin
                store_overflow = 1'b1;
            end
            if (!last) begin
                return;
            end
            want.cost = '0;
            if (store_overflow) begin
                want.status = ST_OVER;
            end else if (dims_count < 2) begin
                want.status = ST_SHORT;
            end else begin
                want.status = ST_OK;
                want.cost   = least_cost(dims_count - 1);
            end
            pending_results = {pending_results, want};
            dims_count     = 0;
            store_overflow = 1'b0;
        endfunction

        function void check_result(logic [COST_W-1:0] cost, logic [STATUS_W-1:0] status);
            t_chain_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: min_cost %0d status %0d", cost, status);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (cost !== want.cost) begin
                $error("min_cost: expected %0d, got %0d", want.cost, cost);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    logic [DIM_PORT_W-1:0] in_dim     = '0;
    logic                  in_last    = 1'b0;
    logic                  out_ready  = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [COST_W-1:0]     o_min_cost;
    logic [STATUS_W-1:0]   o_status;

    t_chain_cost_board board = new();
    int unsigned       items_sent = 0;

    matrix_chain_order_cost #(
        .MAX_MATRICES(MAX_MATRICES),
        .DIM_BITS    (DIM_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_dim      (in_dim),
        .i_last     (in_last),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_min_cost (o_min_cost),
        .o_status   (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic [DIM_PORT_W-1:0] dim, input logic last, input bit quiet);
        int gap;
        gap = pick_gap(quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_dim   <= dim;
        in_last  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_dim(dim, last);
        items_sent++;
    endtask

    task automatic send_dims(input t_dim_q dq, input bit quiet);
        int i;
        for (i = 0; i < dq.size(); i++) begin
            send_item(dq[i], i == dq.size() - 1, quiet);
        end
    endtask

    function automatic logic [DIM_PORT_W-1:0] pick_dim(int mode);
        int r;
        r = $urandom_range(0, 9);
        case (mode)
            0: begin
                return DIM_PORT_W'($urandom);
            end
            1: begin
                return DIM_PORT_W'($urandom_range(0, 15));
            end
            default: begin
                if (r < 3) begin
                    return '0;
                end else if (r < 7) begin
                    return '1;
                end
                return DIM_PORT_W'($urandom);
            end
        endcase
    endfunction

    task automatic send_random_chain(input int ndims, input bit quiet);
        t_dim_q dq;
        int     mode;
        int     i;
        mode = $urandom_range(0, 2);
        for (i = 0; i < ndims; i++) begin
            dq = {dq, pick_dim(mode)};
        end
        send_dims(dq, quiet);
    endtask

    function automatic int pick_chain_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return 1;
        end else if (r < 80) begin
            return $urandom_range(2, 8);
        end else if (r < 95) begin
            return $urandom_range(9, 16);
        end else if (r < 98) begin
            return $urandom_range(17, STORE_DEPTH);
        end
        return $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 7);
    endfunction

    initial begin : stimulus
        t_dim_q dq;
        int     chains;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short chain, single matrix, extremes, textbook case
        dq = '{16'd5};
        send_dims(dq, 1'b0);
        dq = '{16'd0, 16'hffff};
        send_dims(dq, 1'b0);
        dq = '{16'hffff, 16'hffff, 16'hffff};
        send_dims(dq, 1'b0);
        dq = '{16'd10, 16'd30, 16'd5, 16'd60};
        send_dims(dq, 1'b1);
        dq = '{16'hffff, 16'd0, 16'hffff, 16'hffff};
        send_dims(dq, 1'b0);
        dq = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5};
        send_dims(dq, 1'b1);

        // full store, then one that overflows
        send_random_chain(STORE_DEPTH, 1'b0);
        send_random_chain(STORE_DEPTH + 3, 1'b0);

        chains = 0;
        while (items_sent < ITEM_TARGET) begin
            send_random_chain(pick_chain_len(), (chains % 8) == 0);
            chains++;
        end
        in_valid <= 1'b0;

        while (board.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : drain
        int stall_left;
        int results_seen;
        int r;
        stall_left   = 0;
        results_seen = 0;
        forever begin
            @(posedge i_clk);
            if (out_ready && o_out_valid) begin
                board.check_result(o_min_cost, o_status);
                results_seen++;
                // long hold-off so the block backs up into its input
                if (results_seen == 20 || results_seen == 150) begin
                    stall_left = HOLD_CYCLES;
                end
            end
            if (stall_left == 0 && (results_seen % 64) >= 16) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    stall_left = $urandom_range(1, 3);
                end else if (r < 12) begin
                    stall_left = $urandom_range(10, 60);
                end
            end
            out_ready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (out_ready && o_out_valid)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mcoc_pkg.sv
rtl/core/mcoc_ram.sv
rtl/core/mcoc_ctrl.sv
rtl/core/mcoc_dp.sv
rtl/core/matrix_chain_order_cost.sv
tb/tb_matrix_chain_order_cost.sv
